### rtl/lfu_pkg.sv
package lfu_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  // apb register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CFG_IDX_W = PADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } lfu_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
  } lfu_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  typedef struct packed {
    logic               found;
    logic               has_free;
    logic               has_victim;
    logic [DATA_W-1:0]  match_data;
    logic [COUNT_W-1:0] match_count;
    logic [KEY_W-1:0]   victim_key;
  } scan_info_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_WRITE
  } lfu_state_t;

endpackage

### rtl/lfu_slot_ram.sv
module lfu_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 113,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/lfu_scan.sv
module lfu_scan
  import lfu_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                chk_valid,
  input  logic [IDX_W-1:0]    chk_idx,
  input  slot_entry_t         entry,
  input  logic [KEY_W-1:0]    key,
  output scan_info_t          info,
  output logic [IDX_W-1:0]    match_idx,
  output logic [IDX_W-1:0]    free_idx,
  output logic [IDX_W-1:0]    victim_idx
);

  logic [COUNT_W-1:0] victim_count;
  logic [STAMP_W-1:0] victim_stamp;
  logic               less;

  // strict compare keeps the lowest slot on a full tie
  assign less = (entry.count < victim_count) ||
                ((entry.count == victim_count) && (entry.stamp < victim_stamp));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      info.found      <= 1'b0;
      info.has_free   <= 1'b0;
      info.has_victim <= 1'b0;
    end else if (chk_valid) begin
      if (!entry.valid) begin
        if (!info.has_free) begin
          info.has_free <= 1'b1;
          free_idx      <= chk_idx;
        end
      end else begin
        if (!info.found && (entry.key == key)) begin
          info.found       <= 1'b1;
          match_idx        <= chk_idx;
          info.match_data  <= entry.data;
          info.match_count <= entry.count;
        end
        if (!info.has_victim || less) begin
          info.has_victim <= 1'b1;
          victim_idx      <= chk_idx;
          info.victim_key <= entry.key;
          victim_count    <= entry.count;
          victim_stamp    <= entry.stamp;
        end
      end
    end
  end

endmodule

### rtl/lfu_cache_table.sv
// flow: a request is taken only in idle, then scan, tail and write states follow;
//   the scan reads the slot memory through its single read port, one entry a cycle,
//   and the write state holds while the response register is full
// reset: synchronous, active high; afterwards a clearing pass writes every slot
//   empty with req_ready low; capacity register reads 16
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  lfu_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lfu_rsp_t           rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  lfu_state_t          state, state_next;
  logic [IDX_W-1:0]    idx;
  logic                chk_valid;
  logic [IDX_W-1:0]    chk_idx;
  lfu_req_t            req_q;
  logic [CAP_W-1:0]    capacity_in_use;
  logic [CNT_W-1:0]    occupancy;
  logic [STAMP_W-1:0]  access_clock;

  logic                req_fire;
  logic                cfg_write;
  logic [CNT_W-1:0]    cap_eff;
  logic                rsp_free;
  logic                wb_fire;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  slot_entry_t         mem_wdata;
  slot_entry_t         mem_rdata;

  scan_info_t          info;
  logic [IDX_W-1:0]    match_idx, free_idx, victim_idx;

  logic [COUNT_W-1:0]  count_inc;
  logic [STAMP_W-1:0]  stamp_new;
  logic                clock_adv;
  logic                occ_inc;
  lfu_rsp_t            rsp_next;

  assign pready    = 1'b1;
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_CAPACITY) ?
                     PDATA_W'(capacity_in_use) : '0;

  assign cap_eff   = (32'(capacity_in_use) > 32'(SLOTS)) ? CNT_W'(SLOTS) :
                                                            CNT_W'(capacity_in_use);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign wb_fire   = (state == ST_WRITE) && rsp_free;
  assign count_inc = (info.match_count == COUNT_MAX) ? COUNT_MAX : info.match_count + 1'b1;
  assign stamp_new = (access_clock == STAMP_MAX) ? STAMP_MAX : access_clock + 1'b1;

  lfu_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(slot_entry_t)),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  lfu_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (req_fire),
    .chk_valid (chk_valid),
    .chk_idx   (chk_idx),
    .entry     (mem_rdata),
    .key       (req_q.lookup_key),
    .info      (info),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .victim_idx(victim_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = '0;
    clock_adv  = 1'b0;
    occ_inc    = 1'b0;
    rsp_next   = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        mem_wdata.valid = 1'b1;
        mem_wdata.key   = req_q.lookup_key;
        mem_wdata.stamp = stamp_new;
        if (req_q.op == OP_GET) begin
          if (info.found) begin
            mem_we              = 1'b1;
            mem_waddr           = match_idx;
            mem_wdata.data      = info.match_data;
            mem_wdata.count     = count_inc;
            clock_adv           = 1'b1;
            rsp_next.hit        = 1'b1;
            rsp_next.read_value = info.match_data;
          end else begin
            rsp_next.read_value = MISS_VALUE;
          end
        end else if (cap_eff != '0) begin
          mem_wdata.data = req_q.write_value;
          if (info.found) begin
            mem_we          = 1'b1;
            mem_waddr       = match_idx;
            mem_wdata.count = count_inc;
            clock_adv       = 1'b1;
            rsp_next.hit    = 1'b1;
          end else if ((occupancy >= cap_eff) && info.has_victim) begin
            // replace the victim in place, occupancy stays the same
            mem_we               = 1'b1;
            mem_waddr            = victim_idx;
            mem_wdata.count      = COUNT_ONE;
            clock_adv            = 1'b1;
            rsp_next.evicted     = 1'b1;
            rsp_next.evicted_key = info.victim_key;
          end else if (info.has_free) begin
            mem_we          = 1'b1;
            mem_waddr       = free_idx;
            mem_wdata.count = COUNT_ONE;
            clock_adv       = 1'b1;
            occ_inc         = 1'b1;
          end
        end
        // hold everything until the output register is free
        if (!rsp_free) begin
          mem_we    = 1'b0;
          clock_adv = 1'b0;
          occ_inc   = 1'b0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= (state == ST_SCAN);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (req_fire) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
      occupancy       <= '0;
      access_clock    <= '0;
    end else begin
      if (cfg_write && (occupancy == '0)) begin
        capacity_in_use <= pwdata[CAP_W-1:0];
      end
      if (occ_inc) begin
        occupancy <= occupancy + 1'b1;
      end
      if (clock_adv) begin
        access_clock <= stamp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (wb_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

### rtl/lfu_checker.sv
module lfu_checker
  import lfu_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input lfu_rsp_t rsp
);

  // clearing pass keeps the request side closed right after reset
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during clearing pass");

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // an eviction only comes from a put that missed
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.evicted) |-> (!rsp.hit && (rsp.read_value == '0)))
    else $error("eviction reported on a hit or a get");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.evicted) |-> (rsp.evicted_key == '0))
    else $error("evicted key set without an eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);

### test/lfu_cache_table_tb.sv
`timescale 1ns / 1ps

module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int NSLOTS      = SLOTS_DEFAULT;
  localparam int LATENCY     = NSLOTS + 3;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 16;
  localparam int POOL        = 24;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = ~REG_CAPACITY;
  localparam logic [PADDR_W-1:0]   CAP_ADDR      = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0]   UNMAPPED_ADDR = {REG_UNMAPPED, 2'b00};
  localparam logic [CAP_W-1:0]     CAP_TOP       = '1;
  localparam logic [KEY_W-1:0]     KEY_MIN       = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0]     KEY_MAX       = ~KEY_MIN;
  localparam logic [KEY_W-1:0]     KEY_ONES      = '1;

  typedef struct {
    lfu_req_t rq;
    bit       typed;
    lfu_rsp_t rs;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               req_valid;
  logic               req_ready;
  lfu_req_t           req;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  lfu_rsp_t           rsp;

  // shadow of the table
  logic               slot_live  [NSLOTS];
  logic [KEY_W-1:0]   slot_key   [NSLOTS];
  logic [DATA_W-1:0]  slot_val   [NSLOTS];
  logic [COUNT_W-1:0] slot_uses  [NSLOTS];
  logic [STAMP_W-1:0] slot_stamp [NSLOTS];
  logic [STAMP_W-1:0] access_time;
  int                 live_count;
  logic [CAP_W-1:0]   capacity;

  lfu_rsp_t         pending_rsps[$];
  dir_row_t         dir_rows[$];
  logic [KEY_W-1:0] key_pool[POOL];
  lfu_rsp_t         want;
  logic             idle_on;
  int               fail_count = 0;
  int               quiet_cycles = 0;
  int               n_items = 0;
  int               n_hits = 0;
  int               n_evicts = 0;
  int               n_checked = 0;

  always #5 clk = ~clk;

  lfu_cache_table u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp
  );

  function automatic logic [STAMP_W-1:0] next_stamp();
    if (access_time != STAMP_MAX) access_time++;
    return access_time;
  endfunction

  function automatic void bump_entry(int s);
    if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
    slot_stamp[s] = next_stamp();
  endfunction

  function automatic lfu_rsp_t cache_access(lfu_req_t r);
    lfu_rsp_t o;
    int match, free_idx, victim, dst, cap_eff;
    bit found, has_free, has_victim;
    o = '0;
    match = 0;
    free_idx = 0;
    victim = 0;
    found = 0;
    has_free = 0;
    has_victim = 0;
    cap_eff = (capacity > NSLOTS) ? NSLOTS : int'(capacity);
    for (int s = 0; s < NSLOTS; s++) begin
      if (!slot_live[s]) begin
        if (!has_free) begin
          free_idx = s;
          has_free = 1;
        end
      end else begin
        if (!found && slot_key[s] == r.lookup_key) begin
          match = s;
          found = 1;
        end
        // least use count first, then oldest stamp, then lowest slot
        if (!has_victim || slot_uses[s] < slot_uses[victim] ||
            (slot_uses[s] == slot_uses[victim] && slot_stamp[s] < slot_stamp[victim])) begin
          victim = s;
          has_victim = 1;
        end
      end
    end
    if (r.op == OP_GET) begin
      if (found) begin
        o.hit = 1'b1;
        o.read_value = slot_val[match];
        bump_entry(match);
      end else begin
        o.read_value = MISS_VALUE;
      end
    end else if (cap_eff != 0) begin
      if (found) begin
        o.hit = 1'b1;
        slot_val[match] = r.write_value;
        bump_entry(match);
      end else begin
        dst = -1;
        if (live_count >= cap_eff && has_victim) begin
          o.evicted = 1'b1;
          o.evicted_key = slot_key[victim];
          slot_live[victim] = 1'b0;
          live_count--;
          dst = victim;
        end else if (has_free) begin
          dst = free_idx;
        end
        if (dst >= 0) begin
          slot_live[dst]  = 1'b1;
          slot_key[dst]   = r.lookup_key;
          slot_val[dst]   = r.write_value;
          slot_uses[dst]  = COUNT_ONE;
          slot_stamp[dst] = next_stamp();
          live_count++;
        end
      end
    end
    return o;
  endfunction

  function automatic void add_row(logic op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val,
                                  bit typed, logic hit, logic [DATA_W-1:0] rd, logic ev,
                                  logic [KEY_W-1:0] evk);
    dir_row_t row;
    row.rq = '{op: op, lookup_key: key, write_value: val};
    row.typed = typed;
    row.rs = '{hit: hit, read_value: rd, evicted: ev, evicted_key: evk};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 12) return $urandom;
    // skewed toward the low end of the pool so some keys become hot
    return key_pool[$urandom_range(0, $urandom_range(0, POOL - 1))];
  endfunction

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the capacity only changes while the table is empty
    if (addr[PADDR_W-1:2] == REG_CAPACITY && live_count == 0) capacity = data[CAP_W-1:0];
  endtask

  task automatic check_capacity();
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(capacity)) begin
      $error("capacity_in_use: expected %0d, got %0d", capacity, got);
      fail_count++;
    end
  endtask

  task automatic send_req(lfu_req_t r, bit typed, lfu_rsp_t typed_rsp);
    int gap;
    lfu_rsp_t pred;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    pred = cache_access(r);
    pending_rsps.push_back(typed ? typed_rsp : pred);
    n_items++;
    n_hits += pred.hit;
    n_evicts += pred.evicted;
  endtask

  task automatic run_random(int count, int quiet_lo, int quiet_hi);
    lfu_req_t r;
    for (int i = 0; i < count; i++) begin
      idle_on <= !(i >= quiet_lo && i < quiet_hi);
      r.op          = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
      r.lookup_key  = pick_key();
      r.write_value = $urandom;
      send_req(r, 1'b0, '0);
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // response side: random backpressure and field checks
  always @(posedge clk) begin
    rsp_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    if (rsp_valid && rsp_ready) begin
      if (pending_rsps.size() == 0) begin
        $error("response transfer with nothing pending");
        fail_count++;
      end else begin
        want = pending_rsps.pop_front();
        n_checked++;
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
          fail_count++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
          fail_count++;
        end
        if (rsp.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, rsp.evicted_key);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int main_cap;
    int zero_rows;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_valid = 1'b0;
    req       = '0;
    idle_on   = 1'b1;
    for (int s = 0; s < NSLOTS; s++) begin
      slot_live[s]  = 1'b0;
      slot_key[s]   = '0;
      slot_val[s]   = '0;
      slot_uses[s]  = '0;
      slot_stamp[s] = '0;
    end
    access_time = '0;
    live_count  = 0;
    capacity    = CAP_RESET;

    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = KEY_MAX;
    key_pool[3] = KEY_MIN;
    for (int i = 4; i < POOL; i++) key_pool[i] = $urandom;

    // capacity zero: puts do nothing, gets miss
    add_row(OP_GET, '0, KEY_ONES, 1, 1'b0, MISS_VALUE, 1'b0, '0);
    add_row(OP_PUT, KEY_MAX, KEY_MIN, 1, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, KEY_MAX, '0, 1, 1'b0, MISS_VALUE, 1'b0, '0);
    add_row(OP_PUT, KEY_MIN, KEY_ONES, 1, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, KEY_ONES, KEY_MAX, 1, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, KEY_MIN, '0, 1, 1'b0, MISS_VALUE, 1'b0, '0);
    zero_rows = dir_rows.size();
    // nonzero capacity, table starts empty
    add_row(OP_GET, '0, '0, 1, 1'b0, MISS_VALUE, 1'b0, '0);
    add_row(OP_PUT, '0, KEY_MAX, 1, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, '0, KEY_ONES, 1, 1'b1, KEY_MAX, 1'b0, '0);
    add_row(OP_PUT, '0, KEY_MIN, 1, 1'b1, '0, 1'b0, '0);
    add_row(OP_GET, '0, '0, 1, 1'b1, KEY_MIN, 1'b0, '0);
    add_row(OP_PUT, KEY_MIN, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, KEY_MAX, 32'h5555_5555, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, KEY_ONES, 32'hAAAA_AAAA, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, KEY_MIN, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, KEY_ONES, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, KEY_MAX, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, 32'd1, 32'd1, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, 32'd2, 32'd2, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, 32'd3, 32'd3, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, 32'd2, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, 32'd2, '0, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, 32'd4, 32'd4, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_PUT, 32'd5, 32'd5, 0, 1'b0, '0, 1'b0, '0);
    add_row(OP_GET, '0, '0, 0, 1'b0, '0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    do @(posedge clk); while (!req_ready);

    check_capacity();
    reg_write(UNMAPPED_ADDR, '0);
    check_capacity();
    reg_write(CAP_ADDR, '0);
    check_capacity();
    for (int i = 0; i < zero_rows; i++)
      send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
    run_random(40, 0, 0);
    settle();

    reg_write(CAP_ADDR, PDATA_W'(CAP_TOP));
    check_capacity();
    case ($urandom_range(0, 3))
      0: main_cap = 1;
      1: main_cap = NSLOTS;
      2: main_cap = int'(CAP_TOP);
      default: main_cap = $urandom_range(2, NSLOTS - 1);
    endcase
    reg_write(CAP_ADDR, PDATA_W'(main_cap));
    check_capacity();
    for (int i = zero_rows; i < dir_rows.size(); i++)
      send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
    run_random(500, 150, 400);
    settle();

    // table holds entries now, so this write must not take
    reg_write(CAP_ADDR, '0);
    check_capacity();
    run_random(520, 0, 0);
    settle();

    $display("lfu table run: %0d requests, %0d responses checked, %0d hits, %0d evictions",
             n_items, n_checked, n_hits, n_evicts);
    $display("capacity went 16, 0, 31, then %0d; off-map and filled-table writes ignored",
             main_cap);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
